/* rtl/fca_pkg.sv */
// Package for the allocation table chain manager.
// Holds payload types, microcode types, the microcode program and table constants.
// No dependencies; every other file imports this package.
package fca_pkg;

   // Field widths of the request and response words.
   localparam int BLK_W  = 11;
   localparam int LINK_W = 16;
   localparam int PC_W   = 6;
   // Width used for range compares against the block count.
   localparam int CMP_W  = 17;

   // Table entry marks.
   localparam logic [LINK_W-1:0] CHAIN_END = 16'hFFFF;
   localparam logic [LINK_W-1:0] FREE_MARK = 16'h0000;

   // Formatted layout: reserved single-block chains, one two-block chain.
   localparam logic [LINK_W-1:0] RSV_LAST   = 16'd4;
   localparam logic [LINK_W-1:0] PAIR_HEAD  = 16'd5;
   localparam logic [LINK_W-1:0] PAIR_TAIL  = 16'd6;

   // Reset value of the first allocatable block register.
   localparam logic [BLK_W-1:0] FIRST_ALLOC_RST = 11'd7;

   typedef struct packed {
      logic [1:0]       kind;
      logic [BLK_W-1:0] start_block;
      logic [BLK_W-1:0] steps;
      logic             extend;
   } fca_req_type;

   typedef struct packed {
      logic [BLK_W-1:0] block;
      logic [1:0]       status;
      logic [BLK_W-1:0] count;
   } fca_rsp_type;

   typedef enum logic [1:0] {
      KIND_FORMAT = 2'd0,
      KIND_ALLOC  = 2'd1,
      KIND_WALK   = 2'd2,
      KIND_TRUNC  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_END    = 2'd1,
      ST_NOFREE = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   // Read address source of the table memory.
   typedef enum logic [1:0] {
      RA_CUR,
      RA_SCAN,
      RA_NXT
   } ra_type;

   // Table write operation.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,       // table[scan] <= formatted value
      WR_END_FND,    // table[found] <= end of chain
      WR_LINK_CUR,   // table[cur] <= found
      WR_END_CUR,    // table[cur] <= end of chain
      WR_FREE_NXT    // table[nxt] <= free
   } wr_type;

   typedef enum logic [1:0] {
      SC_HOLD,
      SC_ZERO,
      SC_LOAD,
      SC_INC
   } scan_op_type;

   typedef enum logic [1:0] {
      CU_HOLD,
      CU_START,
      CU_NXT,
      CU_FND
   } cur_op_type;

   // Source of the response block field.
   typedef enum logic [1:0] {
      BK_ZERO,
      BK_START,
      BK_CUR,
      BK_FND
   } blk_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_START_BAD,
      C_SCAN_END,
      C_NOT_FREE,
      C_NOT_LAST,
      C_STEPS_DONE,
      C_NXT_END,
      C_NXT_BAD,
      C_NO_EXTEND
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      ra_type           ra;
      wr_type           wr;
      scan_op_type      scan_op;
      cur_op_type       cur_op;
      logic             cnt_inc;
      logic             nxt_ld;
      logic             emit;
      blk_type          blk;
      status_type       status;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   // Datapath status flags tested by jump conditions.
   typedef struct packed {
      logic start_bad;
      logic scan_end;
      logic not_free;
      logic not_last;
      logic steps_done;
      logic nxt_end;
      logic nxt_bad;
      logic no_extend;
   } fca_flags_type;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] UA_IDLE     = 6'd0;
   localparam logic [PC_W-1:0] UA_RST_0    = 6'd1;
   localparam logic [PC_W-1:0] UA_RST_1    = 6'd2;
   localparam logic [PC_W-1:0] UA_RST_2    = 6'd3;
   localparam logic [PC_W-1:0] UA_FMT_0    = 6'd4;
   localparam logic [PC_W-1:0] UA_FMT_1    = 6'd5;
   localparam logic [PC_W-1:0] UA_FMT_2    = 6'd6;
   localparam logic [PC_W-1:0] UA_ALC_0    = 6'd7;
   localparam logic [PC_W-1:0] UA_ALC_1    = 6'd8;
   localparam logic [PC_W-1:0] UA_ALC_2    = 6'd9;
   localparam logic [PC_W-1:0] UA_ALC_3    = 6'd10;
   localparam logic [PC_W-1:0] UA_ALC_4    = 6'd11;
   localparam logic [PC_W-1:0] UA_WLK_0    = 6'd12;
   localparam logic [PC_W-1:0] UA_WLK_1    = 6'd13;
   localparam logic [PC_W-1:0] UA_WLK_2    = 6'd14;
   localparam logic [PC_W-1:0] UA_WLK_3    = 6'd15;
   localparam logic [PC_W-1:0] UA_WLK_4    = 6'd16;
   localparam logic [PC_W-1:0] UA_WLK_5    = 6'd17;
   localparam logic [PC_W-1:0] UA_EXT_0    = 6'd18;
   localparam logic [PC_W-1:0] UA_EXT_1    = 6'd19;
   localparam logic [PC_W-1:0] UA_EXT_2    = 6'd20;
   localparam logic [PC_W-1:0] UA_EXT_3    = 6'd21;
   localparam logic [PC_W-1:0] UA_EXT_4    = 6'd22;
   localparam logic [PC_W-1:0] UA_TRC_0    = 6'd23;
   localparam logic [PC_W-1:0] UA_TRC_1    = 6'd24;
   localparam logic [PC_W-1:0] UA_TRC_2    = 6'd25;
   localparam logic [PC_W-1:0] UA_TRC_3    = 6'd26;
   localparam logic [PC_W-1:0] UA_TRC_4    = 6'd27;
   localparam logic [PC_W-1:0] UA_TRC_5    = 6'd28;
   localparam logic [PC_W-1:0] UA_W_OK     = 6'd29;
   localparam logic [PC_W-1:0] UA_W_EOC    = 6'd30;
   localparam logic [PC_W-1:0] UA_W_NOFREE = 6'd31;
   localparam logic [PC_W-1:0] UA_W_BAD    = 6'd32;
   localparam logic [PC_W-1:0] UA_X_RANGE  = 6'd33;
   localparam logic [PC_W-1:0] UA_T_OK     = 6'd34;
   localparam logic [PC_W-1:0] UA_T_BAD    = 6'd35;

   localparam ucode_type UC_NOP = '{
      ra:      RA_CUR,
      wr:      WR_NONE,
      scan_op: SC_HOLD,
      cur_op:  CU_HOLD,
      cnt_inc: 1'b0,
      nxt_ld:  1'b0,
      emit:    1'b0,
      blk:     BK_ZERO,
      status:  ST_OK,
      cond:    C_NEVER,
      target:  UA_IDLE
   };

   // Formatted value of one table entry.
   function automatic logic [LINK_W-1:0] init_entry(input logic [LINK_W-1:0] idx);
      logic [LINK_W-1:0] val;
      if (idx <= RSV_LAST || idx == PAIR_TAIL) begin
         val = CHAIN_END;
      end else if (idx == PAIR_HEAD) begin
         val = PAIR_TAIL;
      end else begin
         val = FREE_MARK;
      end
      return val;
   endfunction

   // Program entry point of each operation.
   function automatic logic [PC_W-1:0] entry_of(input kind_type k);
      logic [PC_W-1:0] pc;
      unique case (k)
         KIND_FORMAT: pc = UA_FMT_0;
         KIND_ALLOC:  pc = UA_ALC_0;
         KIND_WALK:   pc = UA_WLK_0;
         KIND_TRUNC:  pc = UA_TRC_0;
         default:     pc = UA_IDLE;
      endcase
      return pc;
   endfunction

   // Microprogram read-only table.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = UC_NOP;
      unique case (pc)
         // Clearing pass after reset: no response.
         UA_RST_0: w.scan_op = SC_ZERO;
         UA_RST_1: begin
            w.wr = WR_INIT; w.scan_op = SC_INC;
            w.cond = C_NOT_LAST; w.target = UA_RST_1;
         end
         UA_RST_2: begin
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         // Format: same pass, then respond.
         UA_FMT_0: w.scan_op = SC_ZERO;
         UA_FMT_1: begin
            w.wr = WR_INIT; w.scan_op = SC_INC;
            w.cond = C_NOT_LAST; w.target = UA_FMT_1;
         end
         UA_FMT_2: begin
            w.emit = 1'b1; w.blk = BK_ZERO; w.status = ST_OK;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         // Allocate: free search from the configured first block.
         UA_ALC_0: w.scan_op = SC_LOAD;
         UA_ALC_1: begin
            w.ra = RA_SCAN; w.cond = C_SCAN_END; w.target = UA_ALC_4;
         end
         UA_ALC_2: begin
            w.ra = RA_SCAN;
            w.scan_op = SC_INC; w.cond = C_NOT_FREE; w.target = UA_ALC_1;
         end
         UA_ALC_3: begin
            w.wr = WR_END_FND; w.emit = 1'b1; w.blk = BK_FND; w.status = ST_OK;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_ALC_4: begin
            w.emit = 1'b1; w.blk = BK_ZERO; w.status = ST_NOFREE;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         // Walk: follow links one at a time.
         UA_WLK_0: begin
            w.cur_op = CU_START; w.cond = C_START_BAD; w.target = UA_X_RANGE;
         end
         UA_WLK_1: begin
            w.ra = RA_CUR; w.cond = C_STEPS_DONE; w.target = UA_W_OK;
         end
         UA_WLK_2: w.nxt_ld = 1'b1;
         UA_WLK_3: begin
            w.cond = C_NXT_END; w.target = UA_EXT_0;
         end
         UA_WLK_4: begin
            w.cond = C_NXT_BAD; w.target = UA_W_BAD;
         end
         UA_WLK_5: begin
            w.cur_op = CU_NXT; w.cnt_inc = 1'b1;
            w.cond = C_ALWAYS; w.target = UA_WLK_1;
         end
         // Walk reached the chain end: append a fresh block if asked.
         UA_EXT_0: begin
            w.scan_op = SC_LOAD; w.cond = C_NO_EXTEND; w.target = UA_W_EOC;
         end
         UA_EXT_1: begin
            w.ra = RA_SCAN; w.cond = C_SCAN_END; w.target = UA_W_NOFREE;
         end
         UA_EXT_2: begin
            w.ra = RA_SCAN;
            w.scan_op = SC_INC; w.cond = C_NOT_FREE; w.target = UA_EXT_1;
         end
         UA_EXT_3: begin
            w.wr = WR_LINK_CUR; w.cur_op = CU_FND;
         end
         UA_EXT_4: begin
            w.wr = WR_END_CUR; w.cnt_inc = 1'b1;
            w.cond = C_ALWAYS; w.target = UA_WLK_1;
         end
         // Truncate: terminate the first block, free the rest.
         UA_TRC_0: begin
            w.cur_op = CU_START; w.cond = C_START_BAD; w.target = UA_X_RANGE;
         end
         UA_TRC_1: w.ra = RA_CUR;
         UA_TRC_2: begin
            w.wr = WR_END_CUR; w.nxt_ld = 1'b1;
         end
         UA_TRC_3: begin
            w.cond = C_NXT_END; w.target = UA_T_OK;
         end
         UA_TRC_4: begin
            w.ra = RA_NXT; w.cond = C_NXT_BAD; w.target = UA_T_BAD;
         end
         UA_TRC_5: begin
            w.wr = WR_FREE_NXT; w.nxt_ld = 1'b1; w.cnt_inc = 1'b1;
            w.cond = C_ALWAYS; w.target = UA_TRC_3;
         end
         // Responses.
         UA_W_OK: begin
            w.emit = 1'b1; w.blk = BK_CUR; w.status = ST_OK;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_W_EOC: begin
            w.emit = 1'b1; w.blk = BK_CUR; w.status = ST_END;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_W_NOFREE: begin
            w.emit = 1'b1; w.blk = BK_CUR; w.status = ST_NOFREE;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_W_BAD: begin
            w.emit = 1'b1; w.blk = BK_CUR; w.status = ST_RANGE;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_X_RANGE: begin
            w.emit = 1'b1; w.blk = BK_START; w.status = ST_RANGE;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_T_OK: begin
            w.emit = 1'b1; w.blk = BK_ZERO; w.status = ST_OK;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         UA_T_BAD: begin
            w.emit = 1'b1; w.blk = BK_ZERO; w.status = ST_RANGE;
            w.cond = C_ALWAYS; w.target = UA_IDLE;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

endpackage

/* rtl/fat_chain_allocator_core.sv */
// Top level of the allocation table chain manager.
// Depends on fca_pkg, fca_seq and fca_datapath.

// Keeps a table of NUM_BLOCKS 16-bit entries and runs one operation per word
// taken on the request side (start high while busy is low). Every operation
// gives exactly one response word, shown on rsp_data for one cycle with
// rsp_valid high; the receiver has no way to stall it, so it must take the
// word in that cycle. A microcoded sequencer drives a single table memory with
// one read and one write per cycle and visits entries one by one: format
// rewrites every entry, allocate examines entries upward from the floor, walk
// follows one link at a time and may append a block, and truncate frees one
// block at a time. A start block out of range is answered without touching
// the table. The response word appears in the cycle in which busy falls.
// After reset the table is rewritten to its formatted layout in a pass with
// busy high; csr writes are taken during that pass. csr_wdata is the first
// block index the free search may hand out and should be written only while
// busy is low.
module fat_chain_allocator_core
   import fca_pkg::*;
#(
   parameter int NUM_BLOCKS = 1440
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fca_req_type      req_data,
   output fca_rsp_type      rsp_data,
   output logic             rsp_valid,
   input  logic             csr_we,
   input  logic [BLK_W-1:0] csr_wdata
);

   ucode_type     uword;
   fca_flags_type flags;
   logic          accept;

   // A word is taken only while the sequencer sits idle.
   assign accept = start && !busy;

   fca_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_data.kind),
      .flags (flags),
      .uword (uword),
      .busy  (busy)
   );

   fca_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .uword     (uword),
      .flags     (flags),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

/* rtl/fca_seq.sv */
// Microcode sequencer: step counter, program table and jump logic.
// Depends on fca_pkg for the control word, flags and program addresses.
module fca_seq
   import fca_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    kind,
   input  fca_flags_type flags,
   output ucode_type     uword,
   output logic          busy
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            taken;

   // Current control word comes straight from the program table.
   assign uword = ucode_rom(pc_ff);
   assign busy  = (pc_ff != UA_IDLE);

   // Jump condition selected by the control word.
   always_comb begin
      unique case (uword.cond)
         C_NEVER:      taken = 1'b0;
         C_ALWAYS:     taken = 1'b1;
         C_START_BAD:  taken = flags.start_bad;
         C_SCAN_END:   taken = flags.scan_end;
         C_NOT_FREE:   taken = flags.not_free;
         C_NOT_LAST:   taken = flags.not_last;
         C_STEPS_DONE: taken = flags.steps_done;
         C_NXT_END:    taken = flags.nxt_end;
         C_NXT_BAD:    taken = flags.nxt_bad;
         C_NO_EXTEND:  taken = flags.no_extend;
         default:      taken = 1'b0;
      endcase
   end

   // Next step: dispatch on a new word when idle, else jump or advance.
   always_comb begin
      if (pc_ff == UA_IDLE) begin
         pc_in = start ? entry_of(kind_type'(kind)) : UA_IDLE;
      end else if (taken) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // The step counter starts the clearing pass on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UA_RST_0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* rtl/fca_datapath.sv */
// Datapath: table memory, scan/current/next registers, link counter and response register.
// Depends on fca_pkg; driven by the control word of fca_seq.
module fca_datapath
   import fca_pkg::*;
#(
   parameter int NUM_BLOCKS = 1440
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fca_req_type      req,
   input  logic             csr_we,
   input  logic [BLK_W-1:0] csr_wdata,
   input  ucode_type        uword,
   output fca_flags_type    flags,
   output fca_rsp_type      rsp,
   output logic             rsp_valid
);

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int SW = (AW + 1 > BLK_W) ? AW + 1 : BLK_W;

   logic [LINK_W-1:0] fat_ff [NUM_BLOCKS];

   fca_req_type       req_ff;
   logic [BLK_W-1:0]  csr_ff;
   logic [SW-1:0]     scan_ff;
   logic [SW-1:0]     scan_in;
   logic [AW-1:0]     cur_ff;
   logic [AW-1:0]     cur_in;
   logic [LINK_W-1:0] nxt_ff;
   logic [BLK_W-1:0]  cnt_ff;
   logic [BLK_W-1:0]  cnt_in;
   logic [AW-1:0]     raddr;
   logic [AW-1:0]     raddr_ff;
   logic [LINK_W-1:0] rdata_ff;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [LINK_W-1:0] wdata;
   logic [LINK_W-1:0] blk_wide;
   fca_rsp_type       rsp_ff;
   fca_rsp_type       rsp_in;
   logic              rsp_vld_ff;

   // Table read address.
   always_comb begin
      unique case (uword.ra)
         RA_CUR:  raddr = cur_ff;
         RA_SCAN: raddr = scan_ff[AW-1:0];
         RA_NXT:  raddr = nxt_ff[AW-1:0];
         default: raddr = cur_ff;
      endcase
   end

   // Table write port.
   always_comb begin
      we    = 1'b1;
      waddr = cur_ff;
      wdata = CHAIN_END;
      unique case (uword.wr)
         WR_NONE:     we = 1'b0;
         WR_INIT: begin
            waddr = scan_ff[AW-1:0];
            wdata = init_entry(LINK_W'(scan_ff));
         end
         WR_END_FND:  waddr = raddr_ff;
         WR_LINK_CUR: wdata = LINK_W'(raddr_ff);
         WR_END_CUR:  wdata = CHAIN_END;
         WR_FREE_NXT: begin
            waddr = nxt_ff[AW-1:0];
            wdata = FREE_MARK;
         end
         default:     we = 1'b0;
      endcase
   end

   // Table memory with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         fat_ff[waddr] <= wdata;
      end
      rdata_ff <= fat_ff[raddr];
      raddr_ff <= raddr;
   end

   // Scan index for the clearing pass and the free search.
   always_comb begin
      unique case (uword.scan_op)
         SC_HOLD: scan_in = scan_ff;
         SC_ZERO: scan_in = '0;
         SC_LOAD: scan_in = SW'(csr_ff);
         SC_INC:  scan_in = scan_ff + SW'(1);
         default: scan_in = scan_ff;
      endcase
   end

   // Current block of a walk or truncate.
   always_comb begin
      unique case (uword.cur_op)
         CU_HOLD:  cur_in = cur_ff;
         CU_START: cur_in = AW'(req_ff.start_block);
         CU_NXT:   cur_in = nxt_ff[AW-1:0];
         CU_FND:   cur_in = raddr_ff;
         default:  cur_in = cur_ff;
      endcase
   end

   // Link counter is cleared when a word is taken.
   always_comb begin
      if (accept) begin
         cnt_in = '0;
      end else if (uword.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      scan_ff <= scan_in;
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      if (uword.nxt_ld) begin
         nxt_ff <= rdata_ff;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= FIRST_ALLOC_RST;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // Flags for the jump conditions.
   always_comb begin
      flags.start_bad  = CMP_W'(req_ff.start_block) >= CMP_W'(NUM_BLOCKS);
      flags.scan_end   = CMP_W'(scan_ff) >= CMP_W'(NUM_BLOCKS);
      flags.not_free   = (rdata_ff != FREE_MARK);
      flags.not_last   = CMP_W'(scan_ff) != CMP_W'(NUM_BLOCKS - 1);
      flags.steps_done = (cnt_ff == req_ff.steps);
      flags.nxt_end    = (nxt_ff == CHAIN_END);
      flags.nxt_bad    = (nxt_ff == FREE_MARK) || (CMP_W'(nxt_ff) >= CMP_W'(NUM_BLOCKS));
      flags.no_extend  = !req_ff.extend;
   end

   // Response word.
   always_comb begin
      unique case (uword.blk)
         BK_ZERO:  blk_wide = '0;
         BK_START: blk_wide = LINK_W'(req_ff.start_block);
         BK_CUR:   blk_wide = LINK_W'(cur_ff);
         BK_FND:   blk_wide = LINK_W'(raddr_ff);
         default:  blk_wide = '0;
      endcase
      rsp_in.block  = blk_wide[BLK_W-1:0];
      rsp_in.status = uword.status;
      rsp_in.count  = cnt_ff;
   end

   // The response is held in a register and strobed for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= uword.emit;
      end
      if (uword.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_vld_ff;

endmodule

/* tb/fca_checker.sv */
`timescale 1ns / 100ps
// Response checker for the allocation table chain manager.
// Keeps its own copy of the table, predicts every response word and compares; uses fca_pkg.
module fca_checker
   import fca_pkg::*;
#(
   parameter int NUM_BLOCKS = 1440
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  fca_req_type      req_data,
   input  fca_rsp_type      rsp_data,
   input  logic             rsp_valid,
   input  logic             csr_we,
   input  logic [BLK_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending_words,
   output int               words_checked,
   output logic [3:0]       statuses_seen
);

   // Shadow of the allocation table and of the free search floor.
   logic [LINK_W-1:0] fat_image [NUM_BLOCKS];
   logic [BLK_W-1:0]  alloc_floor;
   fca_rsp_type       awaited_rsp [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      words_checked = 0;
      statuses_seen = '0;
      alloc_floor   = FIRST_ALLOC_RST;
   end

   // Formatted layout: blocks 0 to 4 are single-block chains, 5 links to 6.
   function automatic void format_image();
      for (int i = 0; i < NUM_BLOCKS; i++) fat_image[i] = FREE_MARK;
      for (int i = 0; i < 5; i++) fat_image[i] = CHAIN_END;
      fat_image[5] = 16'd6;
      fat_image[6] = CHAIN_END;
   endfunction

   // Lowest free entry at or above the floor, or -1 when there is none.
   function automatic int lowest_free();
      int found;
      found = -1;
      for (int i = int'(alloc_floor); i < NUM_BLOCKS && found < 0; i++) begin
         if (fat_image[i] == FREE_MARK) found = i;
      end
      return found;
   endfunction

   // Applies one operation to the shadow table and returns its response word.
   function automatic fca_rsp_type predict_table_op(input fca_req_type rq);
      fca_rsp_type rs;
      int          cur;
      int          nxt;
      int          after;
      int          fnd;
      int          links;
      bit          done;
      rs    = '0;
      links = 0;
      done  = 1'b0;
      case (rq.kind)
         KIND_FORMAT: format_image();
         KIND_ALLOC: begin
            fnd = lowest_free();
            if (fnd < 0) begin
               rs.status = ST_NOFREE;
            end else begin
               fat_image[fnd] = CHAIN_END;
               rs.block = BLK_W'(fnd);
            end
         end
         default: begin
            if (rq.start_block >= NUM_BLOCKS) begin
               rs.block  = rq.start_block;
               rs.status = ST_RANGE;
            end else if (rq.kind == KIND_WALK) begin
               // Follow links; at the chain end either stop or append a fresh block.
               cur = rq.start_block;
               while (!done && links < rq.steps) begin
                  nxt = fat_image[cur];
                  if (nxt == CHAIN_END) begin
                     fnd = rq.extend ? lowest_free() : -1;
                     if (!rq.extend) begin
                        rs.status = ST_END;
                        done = 1'b1;
                     end else if (fnd < 0) begin
                        rs.status = ST_NOFREE;
                        done = 1'b1;
                     end else begin
                        fat_image[cur] = LINK_W'(fnd);
                        fat_image[fnd] = CHAIN_END;
                        nxt = fnd;
                     end
                  end else if (nxt == FREE_MARK || nxt >= NUM_BLOCKS) begin
                     rs.status = ST_RANGE;
                     done = 1'b1;
                  end
                  if (!done) begin
                     cur = nxt;
                     links++;
                  end
               end
               rs.block = BLK_W'(cur);
               rs.count = BLK_W'(links);
            end else begin
               // Truncate: the first block becomes the chain end, the rest is freed.
               nxt = fat_image[rq.start_block];
               fat_image[rq.start_block] = CHAIN_END;
               while (!done && nxt != CHAIN_END) begin
                  if (nxt == FREE_MARK || nxt >= NUM_BLOCKS) begin
                     rs.status = ST_RANGE;
                     done = 1'b1;
                  end else begin
                     after = fat_image[nxt];
                     fat_image[nxt] = FREE_MARK;
                     links++;
                     nxt = after;
                  end
               end
               rs.count = BLK_W'(links);
            end
         end
      endcase
      return rs;
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Compares one response word with the oldest prediction.
   task automatic check_word(input fca_rsp_type got);
      fca_rsp_type want;
      words_checked++;
      statuses_seen[got.status] = 1'b1;
      if (awaited_rsp.size() == 0) begin
         report_failure($sformatf("response word with none awaited: block %0d status %0d count %0d",
                                  got.block, got.status, got.count));
      end else begin
         want = awaited_rsp.pop_front();
         if (got.block !== want.block || got.status !== want.status
             || got.count !== want.count) begin
            report_failure($sformatf(
               "word %0d: expected block %0d status %0d count %0d, got block %0d status %0d count %0d",
               words_checked, want.block, want.status, want.count,
               got.block, got.status, got.count));
         end
      end
   endtask

   // Everything is sampled at the rising edge; responses go before new requests.
   always @(posedge clock) begin
      if (reset) begin
         format_image();
         alloc_floor = FIRST_ALLOC_RST;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid === 1'b1) check_word(rsp_data);
         if (csr_we === 1'b1) alloc_floor = csr_wdata;
         if (start === 1'b1 && busy === 1'b0) awaited_rsp.push_back(predict_table_op(req_data));
      end
      pending_words = awaited_rsp.size();
   end

endmodule

/* tb/fat_chain_allocator_core_test.sv */
`timescale 1ns / 100ps
// Top of the allocation table chain manager testbench: clock, reset, stimulus and verdict.
// Depends on fca_pkg, fat_chain_allocator_core and the fca_checker module.
module fat_chain_allocator_core_test;
   import fca_pkg::*;

   localparam int NUM_BLOCKS   = 1440;
   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASES       = 8;
   localparam int QUIET_TAIL   = 150;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   fca_req_type      req_data;
   fca_rsp_type      rsp_data;
   logic             rsp_valid;
   logic             csr_we;
   logic [BLK_W-1:0] csr_wdata;

   int               fail_count;
   int               pending_words;
   int               words_checked;
   logic [3:0]       statuses_seen;
   int               kind_tally [4];
   int               floor_settings;
   logic [BLK_W-1:0] cur_floor;

   fat_chain_allocator_core #(.NUM_BLOCKS(NUM_BLOCKS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   fca_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_data      (rsp_data),
      .rsp_valid     (rsp_valid),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .statuses_seen (statuses_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run, including the clearing pass.
   initial begin
      #100_000_000;
      $display("Timeout with %0d response words still awaited.", pending_words);
      $display("*** FAILED ***");
      $finish;
   end

   // Presents one word at the falling edge and holds it until it is taken.
   task automatic send_word(input fca_req_type w);
      req_data = w;
      start    = 1'b1;
      kind_tally[w.kind]++;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic issue(input kind_type k, input int blk, input int stp, input bit ext);
      fca_req_type w;
      w.kind        = k;
      w.start_block = BLK_W'(blk);
      w.steps       = BLK_W'(stp);
      w.extend      = ext;
      send_word(w);
   endtask

   // Waits at falling edges until every response has come and the block is idle.
   task automatic drain();
      while (pending_words != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   // The floor register is only written while the block is idle.
   task automatic set_floor(input logic [BLK_W-1:0] v);
      drain();
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      cur_floor = v;
      floor_settings++;
   endtask

   // One random operation. Starts cluster where allocations land so chains get walked.
   task automatic random_item(input bit allow_gaps);
      fca_req_type w;
      int          r;
      int          lo;
      int          hi;
      int          blk;
      int          stp;
      bit          ext;
      if (allow_gaps && $urandom_range(0, 99) < 15) repeat ($urandom_range(1, 13)) @(negedge clock);
      if (allow_gaps && $urandom_range(0, 199) == 0) drain();
      lo = (cur_floor < NUM_BLOCKS) ? int'(cur_floor) : 7;
      hi = (lo + 48 < NUM_BLOCKS) ? lo + 48 : NUM_BLOCKS - 1;
      r = $urandom_range(0, 99);
      if (r < 70) blk = $urandom_range(lo, hi);
      else if (r < 80) blk = $urandom_range(0, 6);
      else if (r < 85) blk = $urandom_range(NUM_BLOCKS, 2047);
      else blk = $urandom_range(0, 2047);
      // Long walks never extend, so the table cannot fill in one operation.
      r = $urandom_range(0, 99);
      if (r < 10) begin
         stp = 0;
         ext = 1'($urandom_range(0, 1));
      end else if (r < 65) begin
         stp = $urandom_range(1, 6);
         ext = 1'($urandom_range(0, 1));
      end else if (r < 80) begin
         stp = $urandom_range(7, 40);
         ext = ($urandom_range(0, 3) == 0);
      end else if (r < 95) begin
         stp = $urandom_range(41, NUM_BLOCKS);
         ext = 1'b0;
      end else begin
         stp = $urandom_range(NUM_BLOCKS + 1, 2047);
         ext = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         issue(KIND_FORMAT, $urandom_range(0, 2047), $urandom_range(0, 2047),
               1'($urandom_range(0, 1)));
      end else if (r < 33) begin
         issue(KIND_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 2047),
               1'($urandom_range(0, 1)));
      end else if (r < 70) begin
         issue(KIND_WALK, blk, stp, ext);
      end else if (r < 92) begin
         issue(KIND_TRUNC, blk, $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
      end else begin
         // Noise: any field pattern at all.
         w.kind        = 2'($urandom_range(0, 3));
         w.start_block = BLK_W'($urandom_range(0, 2047));
         w.steps       = BLK_W'($urandom_range(0, 2047));
         w.extend      = (w.steps > 40) ? 1'b0 : 1'($urandom_range(0, 1));
         send_word(w);
      end
   endtask

   initial begin
      logic [BLK_W-1:0] floor_val;
      int               sent;
      reset          = 1'b1;
      start          = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_data       = '0;
      cur_floor      = FIRST_ALLOC_RST;
      floor_settings = 1;
      sent           = 0;
      for (int k = 0; k < 4; k++) kind_tally[k] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);
      @(negedge clock);
      drain();

      // Directed part on the formatted table.
      issue(KIND_WALK, 5, 0, 1'b0);
      issue(KIND_WALK, 5, 3, 1'b0);
      issue(KIND_WALK, 0, 1, 1'b0);
      issue(KIND_WALK, 7, 1, 1'b0);
      issue(KIND_WALK, 2047, 2047, 1'b1);
      issue(KIND_TRUNC, NUM_BLOCKS, 0, 1'b0);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      issue(KIND_ALLOC, 2047, 2047, 1'b1);
      issue(KIND_WALK, 7, 4, 1'b1);
      issue(KIND_WALK, 7, 2047, 1'b0);
      issue(KIND_TRUNC, 7, 0, 1'b0);
      issue(KIND_TRUNC, 20, 0, 1'b0);
      issue(KIND_TRUNC, 5, 0, 1'b0);
      issue(KIND_FORMAT, 2047, 2047, 1'b1);
      // Top floor: one block left, then the table counts as full.
      set_floor(11'd1439);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      issue(KIND_WALK, 5, 3, 1'b1);
      // Extend runs out of free blocks part way; appended blocks stay.
      set_floor(11'd1430);
      issue(KIND_WALK, 5, 20, 1'b1);
      // Floor of zero searches from entry 0.
      set_floor(11'd0);
      issue(KIND_TRUNC, 5, 0, 1'b0);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      // A floor beyond the table finds nothing.
      set_floor(11'd2047);
      issue(KIND_ALLOC, 0, 0, 1'b0);
      issue(KIND_WALK, 0, 2, 1'b1);
      issue(KIND_FORMAT, 0, 0, 1'b0);

      // Random part in phases, each with its own floor; the tail runs without gaps.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       floor_val = 11'd1;
            1:       floor_val = 11'd7;
            2:       floor_val = BLK_W'($urandom_range(8, 120));
            3:       floor_val = BLK_W'($urandom_range(121, 1000));
            4:       floor_val = BLK_W'($urandom_range(1300, 1439));
            5:       floor_val = 11'd0;
            6:       floor_val = BLK_W'($urandom_range(1, 1439));
            default: floor_val = 11'd7;
         endcase
         set_floor(floor_val);
         if ($urandom_range(0, 1) == 1) issue(KIND_FORMAT, 0, 0, 1'b0);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            random_item(sent < RANDOM_ITEMS - QUIET_TAIL);
            sent++;
         end
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d format, %0d allocate, %0d walk and %0d truncate words over %0d floor values.",
               kind_tally[KIND_FORMAT], kind_tally[KIND_ALLOC], kind_tally[KIND_WALK],
               kind_tally[KIND_TRUNC], floor_settings);
      $display("Checked %0d response words; status codes seen (range,nofree,end,ok) = %b.",
               words_checked, statuses_seen);
      if (fail_count == 0 && pending_words == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
